// File: hw/rtl/ttw_pkg.sv
`default_nettype none

package ttw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CELL_W     = $clog2(CELL_COUNT);

  // field widths are fixed by the interface
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int IDX_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_DW = CHAR_W + ATTR_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_TEXT_ATTRIBUTE = '0;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

  typedef struct packed {
    logic               we;
    logic [CELL_W-1:0]  waddr;
    logic [CELL_DW-1:0] wdata;
    logic               re;
    logic [CELL_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/ttw_screen_ram.sv
`default_nettype none

module ttw_screen_ram (
  input  wire logic                   clk,
  input  wire ttw_pkg::ram_req_t      req,
  output logic [ttw_pkg::CELL_DW-1:0] rdata
);
  import ttw_pkg::*;

  logic [CELL_DW-1:0] mem [CELL_COUNT];
  logic [CELL_DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // rdata holds between reads; the controller relies on that
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/ttw_cfg_regs.sv
`default_nettype none

module ttw_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ttw_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [ttw_pkg::CFG_DW-1:0]  pwdata,
  output logic      [ttw_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [ttw_pkg::ATTR_W-1:0]  text_attribute
);
  import ttw_pkg::*;

  logic [ATTR_W-1:0] attr_r;
  logic              sel_attr;

  assign pready   = 1'b1;
  assign sel_attr = (paddr[CFG_AW-1:2] == REG_TEXT_ATTRIBUTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= '0;
    end else if (psel && penable && pwrite && pready && sel_attr) begin
      attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_attr) begin
      prdata = {{(CFG_DW-ATTR_W){1'b0}}, attr_r};
    end
  end

  assign text_attribute = attr_r;

endmodule

`default_nettype wire

// File: hw/rtl/ttw_ctrl.sv
`default_nettype none

module ttw_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ttw_pkg::ATTR_W-1:0]  text_attribute,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_func,
  input  wire logic [ttw_pkg::CHAR_W-1:0]  in_char_code,
  input  wire logic [ttw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ttw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic [ttw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [ttw_pkg::CELL_DW-1:0]      out_cell_data,
  output logic                             out_scrolled,
  output ttw_pkg::ram_req_t                ram_req,
  input  wire logic [ttw_pkg::CELL_DW-1:0] ram_rdata
);
  import ttw_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_RESP} state_t;

  state_t             state_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [CELL_W-1:0]  cnt_r;
  logic               swp_wv_r;
  logic [CELL_W-1:0]  swp_wa_r;
  logic               swp_wc_r;
  logic               swp_end_r;
  logic               copy_r;
  logic               respond_r;
  logic [CELL_DW-1:0] blank_r;
  logic               res_mem_r;
  logic               res_scr_r;

  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [CELL_DW-1:0] out_data_r;
  logic               out_scr_r;

  logic               accept;
  logic               is_ctl;
  logic               printable;
  logic               wrap;
  logic               last_row;
  logic               scroll_now;
  logic               copy_now;
  logic               rd_in_range;
  logic [CELL_W-1:0]  cur_pos;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_ctl    = (in_char_code == CODE_LF) || (in_char_code == CODE_CR);
  assign printable = (in_func == FUNC_PUT) && !is_ctl;
  assign wrap      = (col_r == COL_W'(COLUMNS - 1));
  assign last_row  = (row_r == ROW_W'(ROWS - 1));
  assign scroll_now = (in_func == FUNC_PUT) && (in_char_code != CODE_CR) &&
                      ((in_char_code == CODE_LF) || wrap) && last_row;
  assign copy_now  = copy_r && (cnt_r < CELL_W'(CELL_COUNT - COLUMNS));
  assign rd_in_range = ({{(CELL_W+1-IDX_W){1'b0}}, in_cell_index} <
                        (CELL_W+1)'(CELL_COUNT));
  assign cur_pos   = CELL_W'(CELL_W'(row_r) * CELL_W'(COLUMNS)) + CELL_W'(col_r);

  // one write port shared by put and the sweep; reads lead writes by COLUMNS cells
  always_comb begin
    ram_req = '0;
    if (state_r == S_SWEEP) begin
      ram_req.we    = swp_wv_r;
      ram_req.waddr = swp_wa_r;
      ram_req.wdata = swp_wc_r ? ram_rdata : blank_r;
      ram_req.re    = !swp_end_r && copy_now;
      ram_req.raddr = cnt_r + CELL_W'(COLUMNS);
    end else begin
      ram_req.we    = accept && printable;
      ram_req.waddr = cur_pos;
      ram_req.wdata = {text_attribute, in_char_code};
      ram_req.re    = accept && (in_func == FUNC_READ) && rd_in_range;
      ram_req.raddr = CELL_W'(in_cell_index);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      swp_wv_r    <= 1'b0;
      swp_end_r   <= 1'b0;
      copy_r      <= 1'b0;
      respond_r   <= 1'b0;
      blank_r     <= {{ATTR_W{1'b0}}, CODE_SPACE};
      res_mem_r   <= 1'b0;
      res_scr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_RESP the output register is reloaded or held below
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_mem_r <= (in_func == FUNC_READ) && rd_in_range;
            res_scr_r <= scroll_now;
            state_r   <= (scroll_now || (in_func == FUNC_CLEAR)) ? S_SWEEP : S_RESP;
            case (in_func)
              FUNC_PUT: begin
                if (in_char_code == CODE_CR) begin
                  col_r <= '0;
                end else if ((in_char_code == CODE_LF) || wrap) begin
                  col_r <= '0;
                  if (last_row) begin
                    copy_r    <= 1'b1;
                    respond_r <= 1'b1;
                    blank_r   <= {text_attribute, CODE_SPACE};
                    cnt_r     <= '0;
                  end else begin
                    row_r <= row_r + ROW_W'(1);
                  end
                end else begin
                  col_r <= col_r + COL_W'(1);
                end
              end
              FUNC_CLEAR: begin
                row_r     <= '0;
                col_r     <= '0;
                copy_r    <= 1'b0;
                respond_r <= 1'b1;
                blank_r   <= {text_attribute, CODE_SPACE};
                cnt_r     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (!swp_end_r) begin
            swp_wv_r <= 1'b1;
            swp_wa_r <= cnt_r;
            swp_wc_r <= copy_now;
            cnt_r    <= cnt_r + CELL_W'(1);
            if (cnt_r == CELL_W'(CELL_COUNT - 1)) begin
              swp_end_r <= 1'b1;
            end
          end else begin
            // last cell is written this cycle
            swp_wv_r  <= 1'b0;
            swp_end_r <= 1'b0;
            state_r   <= respond_r ? S_RESP : S_IDLE;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= row_r;
            out_col_r   <= col_r;
            out_data_r  <= res_mem_r ? ram_rdata : '0;
            out_scr_r   <= res_scr_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scr_r;

endmodule

`default_nettype wire

// File: hw/rtl/text_terminal_writer_top.sv
// Order: put, carriage return, line feed, read and unused codes pass to S_RESP after
//   the transaction, then to the output register; scroll and clear first sweep all cells.
// Throughput: one item at a time; a scroll or clear sweeps the screen store through its
//   single write port, one cell per cycle.
// Reset: synchronous, active low; a clearing pass then blanks the store while in_ready
//   stays low. Configuration writes are taken throughout.
`default_nettype none

module text_terminal_writer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ttw_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [ttw_pkg::CFG_DW-1:0]  pwdata,
  output logic      [ttw_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_func,
  input  wire logic [ttw_pkg::CHAR_W-1:0]  in_char_code,
  input  wire logic [ttw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ttw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic [ttw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [ttw_pkg::CELL_DW-1:0]      out_cell_data,
  output logic                             out_scrolled
);
  import ttw_pkg::*;

  logic [ATTR_W-1:0]  text_attribute;
  ram_req_t           ram_req;
  logic [CELL_DW-1:0] ram_rdata;

  ttw_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_attribute (text_attribute)
  );

  ttw_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  ttw_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_attribute (text_attribute),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ttw_checker.sv
`default_nettype none

module ttw_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ttw_pkg::ROW_W-1:0]   out_cursor_row,
  input wire logic [ttw_pkg::COL_W-1:0]   out_cursor_col,
  input wire logic [ttw_pkg::CELL_DW-1:0] out_cell_data,
  input wire logic                        out_scrolled
);
  import ttw_pkg::*;

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_data)
      && $stable(out_cursor_row) && $stable(out_cursor_col) && $stable(out_scrolled))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_row < ROW_W'(ROWS)) && (out_cursor_col < COL_W'(COLUMNS)))
    else $error("cursor out of range");

  // a scroll always leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      (out_cursor_row == ROW_W'(ROWS - 1)) && (out_cursor_col == '0)
      && (out_cell_data == '0))
    else $error("bad cursor after scroll");

endmodule

bind text_terminal_writer_top ttw_checker u_ttw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cursor_row (out_cursor_row),
  .out_cursor_col (out_cursor_col),
  .out_cell_data  (out_cell_data),
  .out_scrolled   (out_scrolled)
);

`default_nettype wire
